// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the sidechain modulation source RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled during reset.
`define SMSU_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("smsu: assertion failed");

// Condition that must never be seen outside reset.
`define SMSU_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("smsu: forbidden condition");

`endif

// ----- rtl/core/smsu_pkg.sv -----
// Shared types, constants and width helpers for the sidechain modulation source.
package smsu_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 16;
  localparam int MUL_B_W         = 17;

  localparam logic [CFG_ADDR_W-1:0] REG_SOURCE_MODE    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ATTACK_COEFF   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_RELEASE_COEFF  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_GATE_THRESHOLD = 3'd3;

  localparam logic [1:0] MODE_ENV  = 2'd0;
  localparam logic [1:0] MODE_GATE = 2'd1;
  localparam logic [1:0] MODE_CV   = 2'd2;
  localparam logic [1:0] MODE_OFF  = 2'd3;

  localparam logic [15:0] ATTACK_RST  = 16'd6554;
  localparam logic [15:0] RELEASE_RST = 16'd66;
  localparam logic [15:0] THRESH_RST  = 16'd2048;

  localparam int HYST_Q412     = 410;
  localparam int CV_SCALE_Q016 = 13107;
  localparam int RECT_MAX      = 32767;
  localparam int ONE_Q115      = 32768;

  typedef struct packed {
    logic [1:0]         source_mode;
    logic [15:0]        attack_coeff;
    logic [15:0]        release_coeff;
    logic signed [15:0] gate_threshold;
  } cfg_t;

  // Width of the multiplier's A operand for a given sample width.
  function automatic int mul_a_w(input int sb);
    return (sb + 1 > 18) ? sb + 1 : 18;
  endfunction

endpackage

// ----- rtl/core/smsu_cfg.sv -----
// Configuration register file with write-only port.
module smsu_cfg
  import smsu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  we,
  input  logic [CFG_ADDR_W-1:0] addr,
  input  logic [CFG_DATA_W-1:0] wdata,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_mode    <= MODE_ENV;
      cfg.attack_coeff   <= ATTACK_RST;
      cfg.release_coeff  <= RELEASE_RST;
      cfg.gate_threshold <= THRESH_RST;
    end else if (we) begin
      unique case (addr)
        REG_SOURCE_MODE:    cfg.source_mode    <= wdata[1:0];
        REG_ATTACK_COEFF:   cfg.attack_coeff   <= wdata;
        REG_RELEASE_COEFF:  cfg.release_coeff  <= wdata;
        REG_GATE_THRESHOLD: cfg.gate_threshold <= wdata;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/smsu_mul.sv -----
// Shared signed multiplier with registered product.
module smsu_mul
  import smsu_pkg::*;
#(
  parameter int AW = 18
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [AW-1:0]          a,
  input  logic signed [MUL_B_W-1:0]     b,
  output logic signed [AW+MUL_B_W-1:0]  p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= a * b;
    end
  end

endmodule

// ----- rtl/core/smsu_ctrl.sv -----
// Sequencer and datapath: envelope, gate, CV scaling, sum and clamp.
`include "assert_macros.svh"

module smsu_ctrl
  import smsu_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int AW          = mul_a_w(SAMPLE_BITS_DEF)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [15:0]            depth,
  input  logic [15:0]                   base_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [15:0]                   param_value,
  output logic                          trigger,
  output logic                          mul_en,
  output logic signed [AW-1:0]          mul_a,
  output logic signed [MUL_B_W-1:0]     mul_b,
  input  logic signed [AW+MUL_B_W-1:0]  mul_p
);

  localparam int PW    = AW + MUL_B_W;
  localparam int LOW_W = AW - 1;
  localparam int TW    = SAMPLE_BITS + 32;
  localparam int DW    = (SAMPLE_BITS + 3 > 20) ? SAMPLE_BITS + 3 : 20;
  localparam int RW    = (SAMPLE_BITS + 1 > 16) ? SAMPLE_BITS + 1 : 16;
  localparam int CW    = (SAMPLE_BITS > 17) ? SAMPLE_BITS : 17;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_E1   = 4'd1;
  localparam logic [3:0] S_E2   = 4'd2;
  localparam logic [3:0] S_E3   = 4'd3;
  localparam logic [3:0] S_E4   = 4'd4;
  localparam logic [3:0] S_GATE = 4'd5;
  localparam logic [3:0] S_C1   = 4'd6;
  localparam logic [3:0] S_C2   = 4'd7;
  localparam logic [3:0] S_C3   = 4'd8;
  localparam logic [3:0] S_C4   = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  logic [3:0]                   state;
  logic signed [SAMPLE_BITS-1:0] s_r;
  logic signed [15:0]           depth_r;
  logic [15:0]                  base_r;
  logic [14:0]                  env;
  logic                         gate_open;
  logic signed [PW-1:0]         hold;
  logic signed [DW-1:0]         delta_r;
  logic                         trig_r;

  // envelope path
  logic signed [RW-1:0]  s_wide;
  logic [RW-1:0]         abs_w;
  logic [14:0]           rect;
  logic signed [16:0]    diff;
  logic [15:0]           coeff;
  logic signed [PW-1:0]  env_rnd;
  logic signed [17:0]    step;
  logic signed [18:0]    env_sum;
  logic [14:0]           env_next;
  logic signed [PW-1:0]  env_dl;

  // gate path
  logic signed [CW-1:0]  s_g;
  logic signed [CW-1:0]  thr_g;
  logic signed [CW-1:0]  thr_lo;
  logic                  gate_rise;
  logic                  gate_next;

  // CV path
  logic signed [PW-1:0]  p1_hi;
  logic signed [TW-1:0]  tot;
  logic signed [TW-1:0]  cv_dl;

  // output sum
  logic signed [DW:0]    sum;
  logic [15:0]           clamped;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    s_wide   = RW'(s_r);
    abs_w    = (s_wide < 0) ? RW'(-s_wide) : RW'(s_wide);
    rect     = (abs_w > RW'(RECT_MAX)) ? 15'(RECT_MAX) : abs_w[14:0];
    diff     = $signed({2'b00, rect}) - $signed({2'b00, env});
    coeff    = (rect > env) ? cfg.attack_coeff : cfg.release_coeff;
    env_rnd  = (mul_p + PW'(32768)) >>> 16;
    step     = env_rnd[17:0];
    env_sum  = $signed({4'b0000, env}) + 19'(step);
    if (env_sum < 0) begin
      env_next = '0;
    end else if (env_sum > 19'(RECT_MAX)) begin
      env_next = 15'(RECT_MAX);
    end else begin
      env_next = env_sum[14:0];
    end
    env_dl = (mul_p + PW'(2048)) >>> 12;

    s_g       = CW'(s_r);
    thr_g     = CW'(cfg.gate_threshold);
    thr_lo    = thr_g - CW'(HYST_Q412);
    gate_rise = !gate_open && (s_g > thr_g);
    gate_next = gate_open ? !(s_g < thr_lo) : gate_rise;

    p1_hi = mul_p >>> LOW_W;
    tot   = (TW'(hold) <<< LOW_W) + TW'(mul_p);
    cv_dl = (tot + TW'(134217728)) >>> 28;

    sum = $signed({{(DW - 15){1'b0}}, base_r}) + (DW + 1)'(delta_r);
    if (sum < 0) begin
      clamped = '0;
    end else if (sum > (DW + 1)'(ONE_Q115)) begin
      clamped = 16'(ONE_Q115);
    end else begin
      clamped = sum[15:0];
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state)
      S_E1: begin
        mul_en = 1'b1;
        mul_a  = AW'(diff);
        mul_b  = $signed({1'b0, coeff});
      end
      S_E3: begin
        mul_en = 1'b1;
        mul_a  = $signed({{(AW - 15){1'b0}}, env});
        mul_b  = MUL_B_W'(depth_r);
      end
      S_C1: begin
        mul_en = 1'b1;
        mul_a  = AW'(s_r);
        mul_b  = MUL_B_W'(depth_r);
      end
      S_C2: begin
        mul_en = 1'b1;
        mul_a  = p1_hi[AW-1:0];
        mul_b  = MUL_B_W'(CV_SCALE_Q016);
      end
      S_C3: begin
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, hold[LOW_W-1:0]});
        mul_b  = MUL_B_W'(CV_SCALE_Q016);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      env       <= '0;
      gate_open <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            s_r     <= sample;
            depth_r <= depth;
            base_r  <= base_value;
            delta_r <= '0;
            trig_r  <= 1'b0;
            unique case (cfg.source_mode)
              MODE_ENV:  state <= S_E1;
              MODE_GATE: state <= S_GATE;
              MODE_CV:   state <= S_C1;
              MODE_OFF:  state <= S_FIN;
            endcase
          end
        end
        S_E1: state <= S_E2;
        S_E2: begin
          env   <= env_next;
          state <= S_E3;
        end
        S_E3: state <= S_E4;
        S_E4: begin
          delta_r <= env_dl[DW-1:0];
          state   <= S_FIN;
        end
        S_GATE: begin
          gate_open <= gate_next;
          trig_r    <= gate_rise;
          delta_r   <= gate_next ? DW'(depth_r) : '0;
          state     <= S_FIN;
        end
        S_C1: state <= S_C2;
        S_C2: begin
          hold  <= mul_p;
          state <= S_C3;
        end
        S_C3: begin
          hold  <= mul_p;
          state <= S_C4;
        end
        S_C4: begin
          delta_r <= cv_dl[DW-1:0];
          state   <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            param_value <= clamped;
            trigger     <= trig_r;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SMSU_ASSERT(a_trig_gate, clk, rst, (out_valid && trigger) |-> (cfg.source_mode == MODE_GATE))
  `SMSU_ASSERT(a_gate_hold, clk, rst, (!$past(rst) && !$stable(gate_open)) |-> ($past(state) == S_GATE))
  `SMSU_ASSERT(a_env_hold, clk, rst, (!$past(rst) && !$stable(env)) |-> ($past(state) == S_E2))

endmodule

// ----- rtl/core/sidechain_modulation_source_unit.sv -----
// Sidechain modulation source: envelope, gate or CV scaling, times depth, plus base.
// From input accept to out_valid: envelope passes states E1 to E4, CV C1 to C4, gate
// GATE; an unused mode goes straight to FIN, which registers the result. One item in
// flight; the next is taken the cycle after the result is registered. Envelope and CV
// use the one shared multiplier, and a new result waits in FIN while the output stalls.
// Synchronous active-high reset: default registers, envelope zero, gate closed, no output.
module sidechain_modulation_source_unit
  import smsu_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [15:0]            depth,
  input  logic [15:0]                   base_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [15:0]                   param_value,
  output logic                          trigger,
  input  logic                          cfg_we,
  input  logic [CFG_ADDR_W-1:0]         cfg_addr,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata
);

  localparam int AW = mul_a_w(SAMPLE_BITS);

  cfg_t                         cfg;
  logic                         mul_en;
  logic signed [AW-1:0]         mul_a;
  logic signed [MUL_B_W-1:0]    mul_b;
  logic signed [AW+MUL_B_W-1:0] mul_p;

  smsu_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .addr  (cfg_addr),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  smsu_mul #(
    .AW (AW)
  ) u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  smsu_ctrl #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .AW          (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .depth       (depth),
    .base_value  (base_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .param_value (param_value),
    .trigger     (trigger),
    .mul_en      (mul_en),
    .mul_a       (mul_a),
    .mul_b       (mul_b),
    .mul_p       (mul_p)
  );

endmodule
